// ===== src/tlj_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text line justifier.
// No dependencies; used by the controller, datapath, top level and checker.
package tlj_pkg;

    localparam int WORD_W        = 8;
    localparam int MAX_WORDS_DEF = 32;
    localparam int DIV_STEPS     = WORD_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
    localparam logic [WORD_W-1:0] WIDTH_RESET = 8'd80;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_OUT  = 5'b01000,
        S_WR   = 5'b10000
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic load_out;
        logic clear_line;
        logic wr;
        logic set_final;
    } t_cmd;

    typedef struct packed {
        logic flush;
        logic div_done;
        logic out_free;
        logic idx_last;
        logic final_mode;
        logic last_in;
    } t_sts;

endpackage

// ===== src/tlj_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the text line justifier: accept, divide, emit, store.
// Depends on tlj_pkg for the state encoding and command/status structs.
module tlj_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tlj_pkg::t_sts  i_sts,
    output tlj_pkg::t_cmd  o_cmd
);
    import tlj_pkg::*;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.flush) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_WR;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.clear_line = 1'b1;
                        n_state          = i_sts.final_mode ? S_IDLE : S_WR;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                if (i_sts.last_in) begin
                    o_cmd.set_final = 1'b1;
                    o_cmd.idx_clr   = 1'b1;
                    n_state         = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/tlj_dpath.sv =====
`timescale 1ns / 1ps
// Datapath for the text line justifier: line buffer memory, fit check,
// serial divider for gap spacing and the output register. Uses tlj_pkg.
module tlj_dpath #(
    parameter int MAX_WORDS = tlj_pkg::MAX_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlj_pkg::t_cmd               i_cmd,
    output tlj_pkg::t_sts               o_sts,
    input  logic                        i_cfg_valid,
    input  logic [tlj_pkg::WORD_W-1:0]  i_line_width,
    input  logic [tlj_pkg::WORD_W-1:0]  i_word_length,
    input  logic                        i_last_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tlj_pkg::WORD_W-1:0]  o_length_out,
    output logic [tlj_pkg::WORD_W-1:0]  o_spaces_after,
    output logic                        o_end_of_line,
    output logic                        o_end_of_text,
    output logic                        o_end_of_run
);
    import tlj_pkg::*;

    localparam int AW   = $clog2(MAX_WORDS);
    localparam int CW   = $clog2(MAX_WORDS + 1);
    localparam int SUMW = WORD_W + 2;

    logic [WORD_W-1:0] r_mem [MAX_WORDS];
    logic [WORD_W-1:0] r_rdata;

    logic [WORD_W-1:0]    r_width;
    logic [WORD_W-1:0]    r_sum;
    logic [CW-1:0]        r_count;
    logic [WORD_W-1:0]    r_word;
    logic                 r_last;
    logic                 r_final;
    logic [AW-1:0]        r_idx;

    logic [WORD_W-1:0]    r_quo;
    logic [CW-1:0]        r_rem;
    logic [CW-1:0]        r_dvs;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic                 r_ovalid;
    logic [WORD_W-1:0]    r_olen;
    logic [WORD_W-1:0]    r_osp;
    logic                 r_oeol;
    logic                 r_oeot;
    logic                 r_oeor;

    logic [SUMW-1:0]      w_need;
    logic                 w_full;
    logic [WORD_W-1:0]    w_total;
    logic [CW-1:0]        w_gaps;
    logic [CW:0]          w_trial;
    logic                 w_ge;
    logic [CW-1:0]        w_idx_ext;
    logic                 w_idx_last;
    logic [SUMW-1:0]      w_used;
    logic [WORD_W-1:0]    w_pad_end;
    logic [WORD_W-1:0]    w_sp;

    assign w_need  = SUMW'(r_sum) + SUMW'(i_word_length) + SUMW'(r_count);
    assign w_full  = (r_count >= CW'(MAX_WORDS));
    assign w_total = (r_width > r_sum) ? (r_width - r_sum) : '0;
    assign w_gaps  = (r_count > CW'(1)) ? (r_count - CW'(1)) : CW'(1);

    assign w_trial = {r_rem, r_quo[WORD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    assign w_idx_ext  = CW'(r_idx);
    assign w_idx_last = (w_idx_ext == (r_count - CW'(1)));
    assign w_used     = SUMW'(r_sum) + SUMW'(r_count) - SUMW'(1);
    assign w_pad_end  = (SUMW'(r_width) > w_used) ?
                        WORD_W'(SUMW'(r_width) - w_used) : '0;

    always_comb begin
        if (r_count == CW'(1)) begin
            w_sp = w_total;
        end else if (r_final) begin
            w_sp = w_idx_last ? w_pad_end : WORD_W'(1);
        end else if (w_idx_last) begin
            w_sp = '0;
        end else begin
            w_sp = r_quo + ((w_idx_ext < r_rem) ? WORD_W'(1) : WORD_W'(0));
        end
    end

    assign o_sts.flush      = (r_count != '0) &&
                              (w_full || (w_need > SUMW'(r_width)));
    assign o_sts.div_done   = (r_div_cnt == '0);
    assign o_sts.out_free   = !r_ovalid || i_ready;
    assign o_sts.idx_last   = w_idx_last;
    assign o_sts.final_mode = r_final;
    assign o_sts.last_in    = r_last;

    // line buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_count[AW-1:0]] <= r_word;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_sum     <= '0;
            r_count   <= '0;
            r_final   <= 1'b0;
            r_idx     <= '0;
            r_div_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_line_width;
            end
            if (i_cmd.clear_line) begin
                r_sum   <= '0;
                r_count <= '0;
            end else if (i_cmd.wr) begin
                r_sum   <= r_sum + r_word;
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.accept) begin
                r_final <= 1'b0;
            end else if (i_cmd.set_final) begin
                r_final <= 1'b1;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // input capture, divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_word <= i_word_length;
            r_last <= i_last_word;
        end
        if (i_cmd.div_start) begin
            r_quo <= w_total;
            r_rem <= '0;
            r_dvs <= w_gaps;
        end else if (r_div_cnt != '0) begin
            r_quo <= {r_quo[WORD_W-2:0], w_ge};
            r_rem <= w_ge ? CW'(w_trial - {1'b0, r_dvs}) : CW'(w_trial);
        end
        if (i_cmd.load_out) begin
            r_olen <= r_rdata;
            r_osp  <= w_sp;
            r_oeol <= w_idx_last;
            r_oeot <= w_idx_last && r_final;
            r_oeor <= w_idx_last && (r_final || !r_last);
        end
    end

    assign o_valid        = r_ovalid;
    assign o_length_out   = r_olen;
    assign o_spaces_after = r_osp;
    assign o_end_of_line  = r_oeol;
    assign o_end_of_text  = r_oeot;
    assign o_end_of_run   = r_oeor;

endmodule

// ===== src/text_line_justifier_unit.sv =====
`timescale 1ns / 1ps
// Top level of the text line justifier: controller plus datapath.
// Depends on tlj_pkg, tlj_ctrl and tlj_dpath.
//
// Greedy full justification of word lengths into lines of line_width
// characters. A word that joins the current line is accepted, then written
// to the line buffer. A word that closes a line first runs the 8-step
// serial divider that splits the spare spaces over the gaps, then each
// emitted word takes a line buffer read and an output register load, the
// load waiting while the output side stalls; a word flagged last_word then
// also emits the words of the final line in the same way. One item is
// processed at a time; the next input transfer is taken once all results
// of the current item sit in or have left the output register. The line
// buffer holds MAX_WORDS lengths in a one-port memory; configuration writes
// are taken in any cycle but must only be issued while the block is idle.
module text_line_justifier_unit #(
    parameter int MAX_WORDS = tlj_pkg::MAX_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tlj_pkg::WORD_W-1:0]  i_line_width,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tlj_pkg::WORD_W-1:0]  i_word_length,
    input  logic                        i_last_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tlj_pkg::WORD_W-1:0]  o_length_out,
    output logic [tlj_pkg::WORD_W-1:0]  o_spaces_after,
    output logic                        o_end_of_line,
    output logic                        o_end_of_text,
    output logic                        o_end_of_run
);
    import tlj_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    tlj_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tlj_dpath #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_line_width   (i_line_width),
        .i_word_length  (i_word_length),
        .i_last_word    (i_last_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_length_out   (o_length_out),
        .o_spaces_after (o_spaces_after),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_text  (o_end_of_text),
        .o_end_of_run   (o_end_of_run)
    );

endmodule

// ===== src/tlj_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the text line justifier, bound to the top level.
// Depends on tlj_pkg and text_line_justifier_unit.
module tlj_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [tlj_pkg::WORD_W-1:0]  o_length_out,
    input logic [tlj_pkg::WORD_W-1:0]  o_spaces_after,
    input logic                        o_end_of_line,
    input logic                        o_end_of_text,
    input logic                        o_end_of_run
);
    import tlj_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_length_out)
            && $stable(o_spaces_after) && $stable(o_end_of_run))
        else $error("stalled result changed");

    a_eot_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_text |-> o_end_of_line && o_end_of_run)
        else $error("end of text without end of line and run");

    a_run_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_line |-> !o_end_of_run)
        else $error("end of run inside a line");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind text_line_justifier_unit tlj_checker u_tlj_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_length_out   (o_length_out),
    .o_spaces_after (o_spaces_after),
    .o_end_of_line  (o_end_of_line),
    .o_end_of_text  (o_end_of_text),
    .o_end_of_run   (o_end_of_run)
);
